FILE: rtl/ppmfd_pkg.sv
// ----------------------------------------------------------------------------
// ppmfd_pkg
// Shared types and constants for the PPM frame decoder.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

  localparam int unsigned ChannelsDef = 8;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PulseW  = 16;
  localparam int unsigned ChIdxW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned OutDataW = 24;

  localparam logic [TimeW-1:0]  SyncMinRst  = 32'd5000;
  localparam logic [TimeW-1:0]  SyncMaxRst  = 32'd30000;
  localparam logic [PulseW-1:0] PulseMinRst = 16'd700;
  localparam logic [PulseW-1:0] PulseMaxRst = 16'd2300;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_MIN  = 2'd0,
    CFG_SYNC_MAX  = 2'd1,
    CFG_PULSE_MIN = 2'd2,
    CFG_PULSE_MAX = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_e;

  typedef struct packed {
    logic edge_en;
    logic rd_start;
    logic rd_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic frame_ready;
    logic rd_last;
  } ctrl_status_t;

endpackage

FILE: rtl/ppm_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// ppm_frame_decoder_unit
// PPM pulse-train decoder: edge timestamps in, latched frames out on read.
//
//   channel  direction  content
//   s_axis   in         tuser opcode, tdata edge_time
//   m_axis   out        tuser frame_valid, tdata index/width, tlast last
//   cfg      in         write enable, register index, 32-bit data
//
// An edge transfer is processed in the cycle it is accepted; one per cycle
// while idle with the output register free. A read emits CHANNELS results,
// one per cycle while the output register is free, from the latched store, or
// a single result when no frame is ready; input is held off until the last
// result is loaded into the output register. Reset is asynchronous and clears
// all state but the result payload; a waiting result holds burst and input.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_unit #(
  parameter int unsigned CHANNELS = ppmfd_pkg::ChannelsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ppmfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ppmfd_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ppmfd_pkg::TimeW-1:0]    s_axis_tdata,  // edge_time
  input  logic                           s_axis_tuser,  // opcode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ppmfd_pkg::OutDataW-1:0] m_axis_tdata,  // channel_index[3:0], pulse_width[19:4]
  output logic                           m_axis_tuser,  // frame_valid
  output logic                           m_axis_tlast
);
  import ppmfd_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  ppmfd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .opcode_i      (s_axis_tuser),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  ppmfd_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .edge_time_i   (s_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: rtl/ppmfd_datapath.sv
// ----------------------------------------------------------------------------
// ppmfd_datapath
// Config registers, gap measurement, capture and latched frame stores,
// read index and the result register.
// ----------------------------------------------------------------------------
module ppmfd_datapath #(
  parameter int unsigned CHANNELS = ppmfd_pkg::ChannelsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppmfd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ppmfd_pkg::CfgW-1:0]       cfg_data_i,
  input  logic [ppmfd_pkg::TimeW-1:0]      edge_time_i,
  input  ppmfd_pkg::ctrl_cmd_t             cmd_i,
  output ppmfd_pkg::ctrl_status_t          status_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ppmfd_pkg::OutDataW-1:0]   m_axis_tdata,  // channel_index, pulse_width
  output logic                             m_axis_tuser,  // frame_valid
  output logic                             m_axis_tlast
);
  import ppmfd_pkg::*;

  localparam int unsigned CntW = $clog2(CHANNELS + 1);
  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CntW-1:0] CntFull = CntW'(CHANNELS);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CHANNELS - 1);

  logic [TimeW-1:0]  sync_min_q, sync_max_q;
  logic [PulseW-1:0] pulse_min_q, pulse_max_q;
  logic [TimeW-1:0]  prev_time_q;
  logic [CntW-1:0]   next_ch_q, next_ch_d;
  logic [PulseW-1:0] capture_q [CHANNELS];
  logic [PulseW-1:0] capture_d [CHANNELS];
  logic [PulseW-1:0] latched_q [CHANNELS];
  logic              frame_ready_q, frame_ready_d;
  logic              latch_en;
  logic              cap_en;
  logic [IdxW-1:0]   rd_idx_q;
  logic [IdxW-1:0]   rd_addr;

  logic              out_valid_q;
  logic              out_fv_q;
  logic [ChIdxW-1:0] out_idx_q;
  logic [PulseW-1:0] out_width_q;
  logic              out_last_q;

  logic [TimeW-1:0]  gap;
  logic              sync_hit, pulse_hit, frame_open;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_min_q  <= SyncMinRst;
      sync_max_q  <= SyncMaxRst;
      pulse_min_q <= PulseMinRst;
      pulse_max_q <= PulseMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SYNC_MIN:  sync_min_q  <= cfg_data_i;
        CFG_SYNC_MAX:  sync_max_q  <= cfg_data_i;
        CFG_PULSE_MIN: pulse_min_q <= cfg_data_i[PulseW-1:0];
        CFG_PULSE_MAX: pulse_max_q <= cfg_data_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  assign gap        = edge_time_i - prev_time_q;
  assign sync_hit   = (gap > sync_min_q) && (gap < sync_max_q);
  assign pulse_hit  = (gap > {16'd0, pulse_min_q}) && (gap < {16'd0, pulse_max_q});
  assign frame_open = (next_ch_q < CntFull);

  always_comb begin
    next_ch_d     = next_ch_q;
    frame_ready_d = frame_ready_q;
    cap_en        = 1'b0;
    latch_en      = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      capture_d[i] = capture_q[i];
    end
    if (cmd_i.edge_en) begin
      priority if (sync_hit) begin
        next_ch_d = '0;
      end else if (!frame_open) begin
        next_ch_d = next_ch_q;
      end else if (pulse_hit) begin
        cap_en    = 1'b1;
        next_ch_d = next_ch_q + CntW'(1);
        capture_d[next_ch_q[IdxW-1:0]] = gap[PulseW-1:0];
        if ((next_ch_d == CntFull) && !frame_ready_q) begin
          latch_en      = 1'b1;
          frame_ready_d = 1'b1;
        end
      end else begin
        next_ch_d = CntFull;
      end
    end
    if (cmd_i.rd_start) begin
      frame_ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q   <= '0;
      next_ch_q     <= '0;
      frame_ready_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        capture_q[i] <= '0;
        latched_q[i] <= '0;
      end
    end else begin
      if (cmd_i.edge_en) begin
        prev_time_q <= edge_time_i;
      end
      next_ch_q     <= next_ch_d;
      frame_ready_q <= frame_ready_d;
      if (cap_en) begin
        for (int i = 0; i < CHANNELS; i++) begin
          capture_q[i] <= capture_d[i];
        end
      end
      if (latch_en) begin
        for (int i = 0; i < CHANNELS; i++) begin
          latched_q[i] <= capture_d[i];
        end
      end
    end
  end

  assign rd_addr = cmd_i.rd_start ? '0 : rd_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_start) begin
      rd_idx_q <= (frame_ready_q && (CHANNELS > 1)) ? IdxW'(1) : '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_q <= (rd_idx_q == IdxLast) ? '0 : rd_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rd_start || cmd_i.rd_next) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_start) begin
      out_fv_q    <= frame_ready_q;
      out_idx_q   <= '0;
      out_width_q <= frame_ready_q ? latched_q[rd_addr] : '0;
      out_last_q  <= !frame_ready_q || (CHANNELS == 1);
    end else if (cmd_i.rd_next) begin
      out_fv_q    <= 1'b1;
      out_idx_q   <= ChIdxW'(rd_addr);
      out_width_q <= latched_q[rd_addr];
      out_last_q  <= (rd_addr == IdxLast);
    end
  end

  assign status_o.out_free    = !out_valid_q || m_axis_tready;
  assign status_o.frame_ready = frame_ready_q;
  assign status_o.rd_last     = (rd_idx_q == IdxLast);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_fv_q;
  assign m_axis_tdata  = {4'd0, out_width_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_read_clears_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_start |=> !frame_ready_q)
    else $error("frame_ready not cleared by read");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_start || cmd_i.rd_next) |-> (!out_valid_q || m_axis_tready))
    else $error("result register overwritten");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.edge_en, cmd_i.rd_start, cmd_i.rd_next}))
    else $error("conflicting datapath commands");

  a_next_ch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_ch_q <= CntFull)
    else $error("capture index out of range");
`endif

endmodule

FILE: rtl/ppmfd_ctrl.sv
// ----------------------------------------------------------------------------
// ppmfd_ctrl
// Sequences edge transfers and read bursts over the datapath.
// ----------------------------------------------------------------------------
module ppmfd_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic                    opcode_i,
  input  ppmfd_pkg::ctrl_status_t status_i,
  output ppmfd_pkg::ctrl_cmd_t    cmd_o
);
  import ppmfd_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = status_i.out_free;
        if (accept) begin
          unique case (opcode_e'(opcode_i))
            OP_EDGE: cmd_o.edge_en = 1'b1;
            OP_READ: begin
              cmd_o.rd_start = 1'b1;
              if (status_i.frame_ready && !status_i.rd_last) begin
                state_d = ST_STREAM;
              end
            end
            default: ;
          endcase
        end
      end
      ST_STREAM: begin
        if (status_i.out_free) begin
          cmd_o.rd_next = 1'b1;
          if (status_i.rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
